// File: hdl/bsim_pkg.sv
// ----------------------------------------------------------------------------
// Bank switch IRQ mapper package
// Shared types, decode codes and helper functions for the mapper core.
// ----------------------------------------------------------------------------
package bsim_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam int PRG_DEPTH = 3;
    localparam int CHR_DEPTH = 8;
    localparam int RLD_DEPTH = 4;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PRG,
        OP_CHR,
        OP_RELOAD,
        OP_LOAD,
        OP_CTRL,
        OP_MIRROR,
        OP_TICK
    } op_t;

    typedef enum logic [1:0] {
        WSEL_16 = 2'd0,
        WSEL_12 = 2'd1,
        WSEL_8  = 2'd2,
        WSEL_4  = 2'd3
    } wsel_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] slot;
        logic       high;
        logic [1:0] nib_sel;
        logic [3:0] nib;
    } dec_t;

    typedef struct packed {
        logic        bank_write;
        logic        bank_is_chr;
        logic [2:0]  bank_slot;
        logic [7:0]  bank_number;
        logic        mirror_write;
        logic [1:0]  mirror_mode;
        logic        irq_raise;
        logic        irq_clear;
        logic [15:0] counter_now;
    } res_t;

    function automatic logic [15:0] width_mask(wsel_t sel);
        logic [15:0] m;
        case (sel)
            WSEL_16: m = 16'hFFFF;
            WSEL_12: m = 16'h0FFF;
            WSEL_8:  m = 16'h00FF;
            WSEL_4:  m = 16'h000F;
            default: m = 16'hFFFF;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] merge_nibble(logic [7:0] old, logic [3:0] nib,
                                                logic high);
        return high ? {nib, old[3:0]} : {old[7:4], nib};
    endfunction

endpackage

// File: hdl/bank_switch_irq_mapper_core.sv
// A word accepted on s_ passes through the input register and then the result register to m_.
// Throughput: one word per cycle while m_ready is high; the input register and the result register
// each move whenever the next stage can take their content.
// The mapper state is read and updated in the single pass between the two.
// Reset (aresetn low, synchronous) clears all bank, reload and counter state
// and empties both registers.
// ----------------------------------------------------------------------------
// Bank switch IRQ mapper core
// Input register, decode and state update, and result register.
// ----------------------------------------------------------------------------
module bank_switch_irq_mapper_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [15:0] s_addr,
    input  logic [7:0]  s_wdata,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_bank_write,
    output logic        m_bank_is_chr,
    output logic [2:0]  m_bank_slot,
    output logic [7:0]  m_bank_number,
    output logic        m_mirror_write,
    output logic [1:0]  m_mirror_mode,
    output logic        m_irq_raise,
    output logic        m_irq_clear,
    output logic [15:0] m_counter_now
);

    logic           in_valid_reg;
    logic           cmd_reg;
    logic [15:0]    addr_reg;
    logic [7:0]     wdata_reg;
    logic           out_valid_reg;
    bsim_pkg::res_t res_reg;
    bsim_pkg::res_t res_next;
    bsim_pkg::dec_t dec;
    logic           advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg   <= s_cmd;
            addr_reg  <= s_addr;
            wdata_reg <= s_wdata;
        end
    end

    bsim_decode u_decode (
        .cmd   (cmd_reg),
        .addr  (addr_reg),
        .wdata (wdata_reg),
        .dec   (dec)
    );

    bsim_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .dec     (dec),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_bank_write   = res_reg.bank_write;
    assign m_bank_is_chr  = res_reg.bank_is_chr;
    assign m_bank_slot    = res_reg.bank_slot;
    assign m_bank_number  = res_reg.bank_number;
    assign m_mirror_write = res_reg.mirror_write;
    assign m_mirror_mode  = res_reg.mirror_mode;
    assign m_irq_raise    = res_reg.irq_raise;
    assign m_irq_clear    = res_reg.irq_clear;
    assign m_counter_now  = res_reg.counter_now;

endmodule

// File: hdl/bsim_decode.sv
// ----------------------------------------------------------------------------
// Bank switch IRQ mapper address decoder
// Turns one registered input word into an operation code and its operands.
// ----------------------------------------------------------------------------
module bsim_decode (
    input  logic               cmd,
    input  logic [15:0]        addr,
    input  logic [7:0]         wdata,
    output bsim_pkg::dec_t     dec
);

    logic [3:0] top;
    logic [3:0] chr_base;

    assign top      = addr[15:12];
    assign chr_base = top - 4'hA;

    always_comb begin
        dec         = '0;
        dec.op      = bsim_pkg::OP_NONE;
        dec.high    = addr[0];
        dec.nib_sel = addr[1:0];
        dec.nib     = wdata[3:0];
        if (cmd == bsim_pkg::CMD_TICK) begin
            dec.op = bsim_pkg::OP_TICK;
        end else begin
            case (top) inside
                4'h8: begin
                    dec.op   = bsim_pkg::OP_PRG;
                    dec.slot = {2'b00, addr[1]};
                end
                4'h9: begin
                    if (!addr[1]) begin
                        dec.op   = bsim_pkg::OP_PRG;
                        dec.slot = 3'd2;
                    end
                end
                [4'hA:4'hD]: begin
                    dec.op   = bsim_pkg::OP_CHR;
                    dec.slot = {chr_base[1:0], addr[1]};
                end
                4'hE: begin
                    dec.op = bsim_pkg::OP_RELOAD;
                end
                4'hF: begin
                    case (addr[1:0])
                        2'd0:    dec.op = bsim_pkg::OP_LOAD;
                        2'd1:    dec.op = bsim_pkg::OP_CTRL;
                        2'd2:    dec.op = bsim_pkg::OP_MIRROR;
                        default: dec.op = bsim_pkg::OP_NONE;
                    endcase
                end
                default: dec.op = bsim_pkg::OP_NONE;
            endcase
        end
    end

endmodule

// File: hdl/bsim_state.sv
// ----------------------------------------------------------------------------
// Bank switch IRQ mapper register file and IRQ counter
// Holds the bank, reload and counter state and forms the result of one word.
// ----------------------------------------------------------------------------
module bsim_state (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  bsim_pkg::dec_t     dec,
    output bsim_pkg::res_t     res
);

    logic [7:0]      prg_reg [bsim_pkg::PRG_DEPTH];
    logic [7:0]      prg_next [bsim_pkg::PRG_DEPTH];
    logic [7:0]      chr_reg [bsim_pkg::CHR_DEPTH];
    logic [7:0]      chr_next [bsim_pkg::CHR_DEPTH];
    logic [3:0]      rld_reg [bsim_pkg::RLD_DEPTH];
    logic [3:0]      rld_next [bsim_pkg::RLD_DEPTH];
    logic [15:0]     count_reg;
    logic [15:0]     count_next;
    bsim_pkg::wsel_t wsel_reg;
    bsim_pkg::wsel_t wsel_next;
    logic            en_reg;
    logic            en_next;

    logic [15:0]     mask;
    logic [15:0]     low;
    logic [7:0]      old_prg;
    logic [7:0]      new_bank;

    assign mask = bsim_pkg::width_mask(wsel_reg);
    assign low  = ((count_reg & mask) - 16'd1) & mask;

    always_comb begin
        case (dec.slot[1:0])
            2'd0:    old_prg = prg_reg[0];
            2'd1:    old_prg = prg_reg[1];
            2'd2:    old_prg = prg_reg[2];
            default: old_prg = '0;
        endcase
    end

    always_comb begin
        prg_next   = prg_reg;
        chr_next   = chr_reg;
        rld_next   = rld_reg;
        count_next = count_reg;
        wsel_next  = wsel_reg;
        en_next    = en_reg;
        new_bank   = '0;
        res        = '0;
        case (dec.op)
            bsim_pkg::OP_PRG: begin
                new_bank = bsim_pkg::merge_nibble(old_prg, dec.nib, dec.high);
                prg_next[dec.slot[1:0]] = new_bank;
                res.bank_write  = 1'b1;
                res.bank_slot   = dec.slot;
                res.bank_number = new_bank;
            end
            bsim_pkg::OP_CHR: begin
                new_bank = bsim_pkg::merge_nibble(chr_reg[dec.slot], dec.nib, dec.high);
                chr_next[dec.slot] = new_bank;
                res.bank_write  = 1'b1;
                res.bank_is_chr = 1'b1;
                res.bank_slot   = dec.slot;
                res.bank_number = new_bank;
            end
            bsim_pkg::OP_RELOAD: begin
                rld_next[dec.nib_sel] = dec.nib;
            end
            bsim_pkg::OP_LOAD: begin
                count_next    = {rld_reg[3], rld_reg[2], rld_reg[1], rld_reg[0]};
                res.irq_clear = 1'b1;
            end
            bsim_pkg::OP_CTRL: begin
                en_next = dec.nib[0];
                if (dec.nib[3]) begin
                    wsel_next = bsim_pkg::WSEL_4;
                end else if (dec.nib[2]) begin
                    wsel_next = bsim_pkg::WSEL_8;
                end else if (dec.nib[1]) begin
                    wsel_next = bsim_pkg::WSEL_12;
                end else begin
                    wsel_next = bsim_pkg::WSEL_16;
                end
                res.irq_clear = 1'b1;
            end
            bsim_pkg::OP_MIRROR: begin
                res.mirror_write = 1'b1;
                res.mirror_mode  = dec.nib[1:0];
            end
            bsim_pkg::OP_TICK: begin
                if (en_reg) begin
                    count_next    = (count_reg & ~mask) | low;
                    res.irq_raise = (low == 16'd0);
                end
            end
            default: begin
            end
        endcase
        res.counter_now = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_reg   <= '{default: '0};
            chr_reg   <= '{default: '0};
            rld_reg   <= '{default: '0};
            count_reg <= '0;
            wsel_reg  <= bsim_pkg::WSEL_16;
            en_reg    <= 1'b0;
        end else if (advance) begin
            prg_reg   <= prg_next;
            chr_reg   <= chr_next;
            rld_reg   <= rld_next;
            count_reg <= count_next;
            wsel_reg  <= wsel_next;
            en_reg    <= en_next;
        end
    end

endmodule

// File: hdl/bsim_checker.sv
// ----------------------------------------------------------------------------
// Bank switch IRQ mapper port checker
// Checks result words and the result handshake seen on the core's ports.
// ----------------------------------------------------------------------------
module bsim_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_bank_write,
    input logic        m_mirror_write,
    input logic        m_irq_raise,
    input logic        m_irq_clear,
    input logic [15:0] m_counter_now
);

    // A word does at most one kind of thing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones({m_bank_write, m_mirror_write, m_irq_raise,
                                m_irq_clear}) <= 1)
        else $error("result word reports more than one action");

    // The low nibble is always counted, so a raised IRQ leaves it at zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_irq_raise) |-> (m_counter_now[3:0] == 4'd0))
        else $error("IRQ raised with nonzero counter low nibble");

    // A stalled result word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_counter_now)))
        else $error("stalled result word changed");

    // Reset empties the result register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind bank_switch_irq_mapper_core bsim_checker u_bsim_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_bank_write   (m_bank_write),
    .m_mirror_write (m_mirror_write),
    .m_irq_raise    (m_irq_raise),
    .m_irq_clear    (m_irq_clear),
    .m_counter_now  (m_counter_now)
);
